// ===== design/adps_pkg.sv =====
// adps_pkg: shared constants, types and arithmetic helpers for the
// agent disease progression step pipeline. No dependencies.

package adps_pkg;

   // Fixed-point format of all fractions (1.0 = 1 << FracBits)
   localparam int FracBits = 16;
   localparam int FixW     = FracBits + 1;
   // Upper part of a FixW x FixW product after dropping the fraction bits
   localparam int ProdHiW  = 2 * FixW - FracBits;
   localparam logic [FixW-1:0] FixOne = FixW'(1) << FracBits;

   // Vaccine buildup table
   localparam int VaccineDays = 21;
   localparam int VacIdxW     = $clog2(VaccineDays);

   // Field widths
   localparam int CdW   = 7;
   localparam int UpW   = 8;
   localparam int IncW  = 4;
   localparam int VdW   = 6;
   localparam int DrawW = 16;
   localparam int OffW  = 5;
   localparam int MinW  = 5;

   // Configuration register indexes
   localparam int CsrIdxW = 3;
   typedef enum logic [CsrIdxW-1:0] {
      CSR_SYM_FRAC  = 3'd0,
      CSR_ASYM_LVL  = 3'd1,
      CSR_EFF_INF   = 3'd2,
      CSR_EFF_SUS   = 3'd3,
      CSR_EFF_SYM   = 3'd4,
      CSR_MIN_DAYS  = 3'd5
   } csr_index_type;

   // Record carried down the pipeline; later stages fill in the derived terms
   typedef struct packed {
      logic [CdW-1:0]     cd;        // infectious countdown (two's complement)
      logic [UpW-1:0]     up;        // infectious day count
      logic [IncW-1:0]    inc;       // incubation left (two's complement)
      logic [VdW-1:0]     vd;        // vaccine day, already advanced
      logic [FixW-1:0]    binf;
      logic [FixW-1:0]    inf;
      logic [FixW-1:0]    bsus;
      logic [FixW-1:0]    sus;
      logic               sym;
      logic               cas;
      logic [DrawW-1:0]   draw;
      logic               onset;     // incubation ended this day
      logic               vacc;
      logic               cd_pos;    // countdown positive after the step
      logic [FixW-1:0]    bld;       // vaccine buildup
      logic [FixW-1:0]    keep_sym;
      logic [FixW-1:0]    keep_inf;
      logic [FixW-1:0]    keep_sus;
      logic [ProdHiW-1:0] thr;       // symptom threshold
   } rec_type;

   // Vaccine buildup by day, Q16
   function automatic logic [FixW-1:0] buildup(input logic [VacIdxW-1:0] idx);
      logic [FixW-1:0] val;
      case (idx)
         5'd0:    val = 17'd83;
         5'd1:    val = 17'd549;
         5'd2:    val = 17'd1654;
         5'd3:    val = 17'd3615;
         5'd4:    val = 17'd6632;
         5'd5:    val = 17'd10886;
         5'd6:    val = 17'd16548;
         5'd7:    val = 17'd23790;
         5'd8:    val = 17'd32768;
         5'd9:    val = 17'd32768;
         5'd10:   val = 17'd32768;
         5'd11:   val = 17'd32768;
         5'd12:   val = 17'd32768;
         5'd13:   val = 17'd32768;
         5'd14:   val = 17'd32932;
         5'd15:   val = 17'd33856;
         5'd16:   val = 17'd36045;
         5'd17:   val = 17'd39924;
         5'd18:   val = 17'd45895;
         5'd19:   val = 17'd54316;
         default: val = 17'd65536;
      endcase
      return val;
   endfunction

   // Truncated fixed-point product, integer part kept
   function automatic logic [ProdHiW-1:0] fmul(input logic [FixW-1:0] a,
                                               input logic [FixW-1:0] b);
      logic [2*FixW-1:0] prod;
      prod = a * b;
      return prod[2*FixW-1:FracBits];
   endfunction

   // 1 - eff*b, floored at zero
   function automatic logic [FixW-1:0] keep_frac(input logic [FixW-1:0] eff,
                                                 input logic [FixW-1:0] b);
      logic [ProdHiW-1:0] cut;
      logic [ProdHiW-1:0] one_w;
      one_w = ProdHiW'(FixOne);
      cut   = fmul(eff, b);
      if (cut >= one_w) begin
         return '0;
      end
      return FixW'(one_w - cut);
   endfunction

endpackage

// ===== design/agent_disease_progression_step.sv =====
// agent_disease_progression_step: five-stage pipeline that advances one
// person's disease record by one simulated day. Depends on adps_pkg.

// An item is taken whenever start is high; busy never rises, so one item
// can enter every cycle and its result leaves the s5 register on the rsp_
// ports, marked by rsp_strobe for one cycle. The result path has no
// backpressure: a result is presented exactly once and must be captured.
// The stage split is set by the two dependent 17x17 multiplies (vaccine
// keep factor, then symptom threshold) ahead of the draw compare and the
// final vaccine scaling multiply. Configuration registers are written
// through the csr_ channel (always ready) and must only change while no
// item is in flight.
//
// Stage map:
//   s1  countdown, incubation and vaccine-day update; buildup ROM lookup
//   s2  three keep factors 1 - eff*buildup (symptoms, infectious, susceptible)
//   s3  symptom threshold = keep_sym * symptomatic_fraction if vaccinated, else the fraction
//   s4  symptomatic / asymptomatic choice at onset of infectiousness
//   s5  vaccine scaling of infectiousness or susceptibility; output register

module agent_disease_progression_step (
   input  logic        clock,
   input  logic        reset,

   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data,

   // request
   input  logic        start,
   output logic        busy,
   input  logic [6:0]  req_infectious_left,
   input  logic [7:0]  req_infectious_elapsed,
   input  logic [3:0]  req_incubation_left,
   input  logic [5:0]  req_vaccine_day,
   input  logic [16:0] req_base_infectious_in,
   input  logic [16:0] req_infectious_in,
   input  logic [16:0] req_base_suscept_in,
   input  logic [16:0] req_suscept_in,
   input  logic        req_symptomatic_in,
   input  logic        req_case_in,
   input  logic [15:0] req_symptom_draw,
   input  logic [4:0]  req_duration_offset,

   // response
   output logic        rsp_strobe,
   output logic [6:0]  rsp_infectious_left_out,
   output logic [7:0]  rsp_infectious_elapsed_out,
   output logic [3:0]  rsp_incubation_left_out,
   output logic [5:0]  rsp_vaccine_day_out,
   output logic [16:0] rsp_base_infectious_out,
   output logic [16:0] rsp_infectious_out,
   output logic [16:0] rsp_base_suscept_out,
   output logic [16:0] rsp_suscept_out,
   output logic        rsp_symptomatic_out,
   output logic        rsp_case_out,
   output logic        rsp_newly_infectious
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [adps_pkg::FixW-1:0] sym_frac_ff, asym_lvl_ff;
   logic [adps_pkg::FixW-1:0] eff_inf_ff, eff_sus_ff, eff_sym_ff;
   logic [adps_pkg::MinW-1:0] min_days_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_frac_ff <= 17'd6554;
         asym_lvl_ff <= 17'd6554;
         eff_inf_ff  <= 17'd32768;
         eff_sus_ff  <= 17'd0;
         eff_sym_ff  <= 17'd41943;
         min_days_ff <= 5'd7;
      end else if (csr_valid && csr_ready) begin
         case (adps_pkg::csr_index_type'(csr_index))
            adps_pkg::CSR_SYM_FRAC: sym_frac_ff <= csr_data;
            adps_pkg::CSR_ASYM_LVL: asym_lvl_ff <= csr_data;
            adps_pkg::CSR_EFF_INF:  eff_inf_ff  <= csr_data;
            adps_pkg::CSR_EFF_SUS:  eff_sus_ff  <= csr_data;
            adps_pkg::CSR_EFF_SYM:  eff_sym_ff  <= csr_data;
            adps_pkg::CSR_MIN_DAYS: min_days_ff <= csr_data[adps_pkg::MinW-1:0];
            default: ;  // indexes past the list are dropped
         endcase
      end
   end

   // Pipeline never stalls
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // Pipeline registers
   // ---------------------------------------------------------------
   adps_pkg::rec_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   adps_pkg::rec_type s1_in, s2_in, s3_in, s4_in, s5_in;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_valid_in;

   assign s1_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
   end

   // ---------------------------------------------------------------
   // s1: day counters and buildup lookup
   // ---------------------------------------------------------------
   logic                           cd_neg, cd_zero, cd_pos;
   logic                           inc_neg, inc_zero, inc_pos;
   logic [adps_pkg::CdW-1:0]       cd_dec;
   logic [adps_pkg::UpW-1:0]       up_inc;
   logic [adps_pkg::MinW:0]        onset_days;   // min + offset, at most 62
   logic [adps_pkg::VacIdxW-1:0]   bld_idx;

   always_comb begin
      cd_neg   = req_infectious_left[adps_pkg::CdW-1];
      cd_zero  = (req_infectious_left == '0);
      cd_pos   = !cd_neg && !cd_zero;
      inc_neg  = req_incubation_left[adps_pkg::IncW-1];
      inc_zero = (req_incubation_left == '0);
      inc_pos  = !inc_neg && !inc_zero;

      cd_dec = req_infectious_left - adps_pkg::CdW'(1);
      // elapsed count saturates at all ones
      up_inc = (&req_infectious_elapsed) ? req_infectious_elapsed
                                         : req_infectious_elapsed + adps_pkg::UpW'(1);
      onset_days = {1'b0, min_days_ff} + {1'b0, req_duration_offset};

      // day index past the table sticks at the last entry
      if (req_vaccine_day > adps_pkg::VdW'(adps_pkg::VaccineDays - 1)) begin
         bld_idx = adps_pkg::VacIdxW'(adps_pkg::VaccineDays - 1);
      end else begin
         bld_idx = req_vaccine_day[adps_pkg::VacIdxW-1:0];
      end

      s1_in          = '0;
      s1_in.cd       = req_infectious_left;
      s1_in.up       = req_infectious_elapsed;
      s1_in.inc      = req_incubation_left;
      s1_in.vd       = req_vaccine_day;
      s1_in.binf     = req_base_infectious_in;
      s1_in.inf      = req_infectious_in;
      s1_in.bsus     = req_base_suscept_in;
      s1_in.sus      = req_suscept_in;
      s1_in.sym      = req_symptomatic_in;
      s1_in.cas      = req_case_in;
      s1_in.draw     = req_symptom_draw;
      s1_in.vacc     = !req_vaccine_day[adps_pkg::VdW-1];
      s1_in.bld      = adps_pkg::buildup(bld_idx);

      // infectious countdown
      if (cd_pos) begin
         s1_in.cd = cd_dec;
         s1_in.up = up_inc;
      end else if (cd_zero) begin
         s1_in.binf = '0;
         s1_in.inf  = '0;
         s1_in.sym  = 1'b0;
      end

      // incubation; the symptom choice itself is made in s4
      if (inc_pos) begin
         s1_in.inc = req_incubation_left - adps_pkg::IncW'(1);
      end else if (inc_zero) begin
         s1_in.inc   = '1;
         s1_in.onset = 1'b1;
         s1_in.cd    = adps_pkg::CdW'(onset_days);
         s1_in.up    = '0;
      end

      s1_in.cd_pos = !s1_in.cd[adps_pkg::CdW-1] && (s1_in.cd != '0);

      // vaccine day advances until the last table day
      if (s1_in.vacc &&
          req_vaccine_day < adps_pkg::VdW'(adps_pkg::VaccineDays - 1)) begin
         s1_in.vd = req_vaccine_day + adps_pkg::VdW'(1);
      end
   end

   // ---------------------------------------------------------------
   // s2: keep factors 1 - eff*buildup
   // ---------------------------------------------------------------
   always_comb begin
      s2_in          = s1_ff;
      s2_in.keep_sym = adps_pkg::keep_frac(eff_sym_ff, s1_ff.bld);
      s2_in.keep_inf = adps_pkg::keep_frac(eff_inf_ff, s1_ff.bld);
      s2_in.keep_sus = adps_pkg::keep_frac(eff_sus_ff, s1_ff.bld);
   end

   // ---------------------------------------------------------------
   // s3: symptom threshold
   // ---------------------------------------------------------------
   always_comb begin
      s3_in = s2_ff;
      if (s2_ff.vacc) begin
         s3_in.thr = adps_pkg::fmul(s2_ff.keep_sym, sym_frac_ff);
      end else begin
         s3_in.thr = adps_pkg::ProdHiW'(sym_frac_ff);
      end
   end

   // ---------------------------------------------------------------
   // s4: symptomatic or asymptomatic onset
   // ---------------------------------------------------------------
   always_comb begin
      s4_in = s3_ff;
      if (s3_ff.onset) begin
         if (adps_pkg::ProdHiW'(s3_ff.draw) < s3_ff.thr) begin
            s4_in.sym  = 1'b1;
            s4_in.cas  = 1'b1;
            s4_in.binf = adps_pkg::FixOne;
            s4_in.inf  = adps_pkg::FixOne;
         end else begin
            s4_in.sym  = 1'b0;
            s4_in.cas  = 1'b0;
            s4_in.binf = asym_lvl_ff;
            s4_in.inf  = asym_lvl_ff;
         end
      end
   end

   // ---------------------------------------------------------------
   // s5: vaccine scaling; results leave from this register
   // ---------------------------------------------------------------
   logic [adps_pkg::ProdHiW-1:0] inf_scaled, sus_scaled;

   always_comb begin
      inf_scaled = adps_pkg::fmul(s4_ff.binf, s4_ff.keep_inf);
      sus_scaled = adps_pkg::fmul(s4_ff.bsus, s4_ff.keep_sus);
      s5_in = s4_ff;
      if (s4_ff.vacc) begin
         if (s4_ff.cd_pos) begin
            s5_in.inf = inf_scaled[adps_pkg::FixW-1:0];
         end else if (s4_ff.bsus != '0) begin
            s5_in.sus = sus_scaled[adps_pkg::FixW-1:0];
         end
      end
   end

   assign rsp_strobe                 = s5_valid_ff;
   assign rsp_infectious_left_out    = s5_ff.cd;
   assign rsp_infectious_elapsed_out = s5_ff.up;
   assign rsp_incubation_left_out    = s5_ff.inc;
   assign rsp_vaccine_day_out        = s5_ff.vd;
   assign rsp_base_infectious_out    = s5_ff.binf;
   assign rsp_infectious_out         = s5_ff.inf;
   assign rsp_base_suscept_out       = s5_ff.bsus;
   assign rsp_suscept_out            = s5_ff.sus;
   assign rsp_symptomatic_out        = s5_ff.sym;
   assign rsp_case_out               = s5_ff.cas;
   assign rsp_newly_infectious       = (s5_ff.up == '0);

endmodule

// ===== tb/sv/disease_step_checker.sv =====
// disease_step_checker: watches the csr_, req_ and rsp_ channels of the disease
// progression step, predicts each day's record and compares it with the result.
// Depends on adps_pkg for field widths and register indexes.

module disease_step_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [adps_pkg::CsrIdxW-1:0] csr_index,
   input  logic [adps_pkg::FixW-1:0]    csr_data,
   input  logic                         start,
   input  logic                         busy,
   input  logic [adps_pkg::CdW-1:0]     req_infectious_left,
   input  logic [adps_pkg::UpW-1:0]     req_infectious_elapsed,
   input  logic [adps_pkg::IncW-1:0]    req_incubation_left,
   input  logic [adps_pkg::VdW-1:0]     req_vaccine_day,
   input  logic [adps_pkg::FixW-1:0]    req_base_infectious_in,
   input  logic [adps_pkg::FixW-1:0]    req_infectious_in,
   input  logic [adps_pkg::FixW-1:0]    req_base_suscept_in,
   input  logic [adps_pkg::FixW-1:0]    req_suscept_in,
   input  logic                         req_symptomatic_in,
   input  logic                         req_case_in,
   input  logic [adps_pkg::DrawW-1:0]   req_symptom_draw,
   input  logic [adps_pkg::OffW-1:0]    req_duration_offset,
   input  logic                         rsp_strobe,
   input  logic [adps_pkg::CdW-1:0]     rsp_infectious_left_out,
   input  logic [adps_pkg::UpW-1:0]     rsp_infectious_elapsed_out,
   input  logic [adps_pkg::IncW-1:0]    rsp_incubation_left_out,
   input  logic [adps_pkg::VdW-1:0]     rsp_vaccine_day_out,
   input  logic [adps_pkg::FixW-1:0]    rsp_base_infectious_out,
   input  logic [adps_pkg::FixW-1:0]    rsp_infectious_out,
   input  logic [adps_pkg::FixW-1:0]    rsp_base_suscept_out,
   input  logic [adps_pkg::FixW-1:0]    rsp_suscept_out,
   input  logic                         rsp_symptomatic_out,
   input  logic                         rsp_case_out,
   input  logic                         rsp_newly_infectious,
   output int unsigned                  mismatches,
   output int unsigned                  waiting,
   output int unsigned                  checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ReportLimit = 10;
   localparam int FieldW      = adps_pkg::FixW;  // widest result field
   localparam logic [63:0] Q16One = 64'd1 << adps_pkg::FracBits;

   typedef struct packed {
      logic [adps_pkg::CdW-1:0]   cd;
      logic [adps_pkg::UpW-1:0]   up;
      logic [adps_pkg::IncW-1:0]  inc;
      logic [adps_pkg::VdW-1:0]   vd;
      logic [adps_pkg::FixW-1:0]  binf;
      logic [adps_pkg::FixW-1:0]  inf;
      logic [adps_pkg::FixW-1:0]  bsus;
      logic [adps_pkg::FixW-1:0]  sus;
      logic                       sym;
      logic                       cas;
      logic [adps_pkg::DrawW-1:0] draw;
      logic [adps_pkg::OffW-1:0]  offs;
   } day_in_type;

   typedef struct packed {
      logic [adps_pkg::CdW-1:0]   cd;
      logic [adps_pkg::UpW-1:0]   up;
      logic [adps_pkg::IncW-1:0]  inc;
      logic [adps_pkg::VdW-1:0]   vd;
      logic [adps_pkg::FixW-1:0]  binf;
      logic [adps_pkg::FixW-1:0]  inf;
      logic [adps_pkg::FixW-1:0]  bsus;
      logic [adps_pkg::FixW-1:0]  sus;
      logic                       sym;
      logic                       cas;
      logic                       fresh;
   } day_out_type;

   // shadow of the block's registers
   logic [adps_pkg::FixW-1:0] sym_frac, asym_lvl, eff_inf, eff_sus, eff_sym;
   logic [adps_pkg::MinW-1:0] min_days;

   logic [adps_pkg::FixW-1:0] buildup_by_day [adps_pkg::VaccineDays];
   day_out_type               expected_days [$];

   initial begin
      buildup_by_day = '{83, 549, 1654, 3615, 6632, 10886, 16548, 23790,
                         32768, 32768, 32768, 32768, 32768, 32768,
                         32932, 33856, 36045, 39924, 45895, 54316, 65536};
   end

   // 1 - eff*buildup, held at zero
   function automatic logic [63:0] keep_after(input logic [adps_pkg::FixW-1:0] eff,
                                              input logic [63:0] b);
      logic [63:0] cut;
      cut = (64'(eff) * b) >> adps_pkg::FracBits;
      return (cut >= Q16One) ? 64'd0 : Q16One - cut;
   endfunction

   function automatic day_out_type advance_day(input day_in_type d);
      day_out_type                  o;
      int                           cd, inc, vd;
      logic [adps_pkg::VacIdxW-1:0] day_idx;
      logic [adps_pkg::UpW-1:0]     up;
      logic [63:0]                  binf, inf, bsus, sus, bld, thr;
      logic                         sym, cas, vacc;
      cd   = int'($signed(d.cd));
      inc  = int'($signed(d.inc));
      vd   = int'($signed(d.vd));
      up   = d.up;
      binf = 64'(d.binf);
      inf  = 64'(d.inf);
      bsus = 64'(d.bsus);
      sus  = 64'(d.sus);
      sym  = d.sym;
      cas  = d.cas;
      vacc = (vd >= 0);
      // days past the table read its last entry
      if (vd > adps_pkg::VaccineDays - 1)
         day_idx = adps_pkg::VacIdxW'(adps_pkg::VaccineDays - 1);
      else if (vd < 0)
         day_idx = '0;
      else
         day_idx = adps_pkg::VacIdxW'(vd);
      bld  = vacc ? 64'(buildup_by_day[day_idx]) : 64'd0;

      if (cd > 0) begin
         cd--;
         if (up != '1) up++;
      end else if (cd == 0) begin
         binf = '0;
         inf  = '0;
         sym  = 1'b0;
      end

      if (inc > 0) begin
         inc--;
      end else if (inc == 0) begin
         inc = -1;
         thr = vacc ? (keep_after(eff_sym, bld) * 64'(sym_frac)) >> adps_pkg::FracBits
                    : 64'(sym_frac);
         if (64'(d.draw) < thr) begin
            sym  = 1'b1;
            cas  = 1'b1;
            binf = Q16One;
            inf  = Q16One;
         end else begin
            sym  = 1'b0;
            cas  = 1'b0;
            binf = 64'(asym_lvl);
            inf  = 64'(asym_lvl);
         end
         cd = int'(min_days) + int'(d.offs);
         up = '0;
      end

      if (vacc) begin
         if (cd > 0) begin
            inf = (binf * keep_after(eff_inf, bld)) >> adps_pkg::FracBits;
         end else if (bsus != 0) begin
            sus = (bsus * keep_after(eff_sus, bld)) >> adps_pkg::FracBits;
         end
         if (vd < adps_pkg::VaccineDays - 1) vd++;
      end

      o.cd    = adps_pkg::CdW'(cd);
      o.up    = up;
      o.inc   = adps_pkg::IncW'(inc);
      o.vd    = adps_pkg::VdW'(vd);
      o.binf  = adps_pkg::FixW'(binf);
      o.inf   = adps_pkg::FixW'(inf);
      o.bsus  = adps_pkg::FixW'(bsus);
      o.sus   = adps_pkg::FixW'(sus);
      o.sym   = sym;
      o.cas   = cas;
      o.fresh = (up == '0);
      return o;
   endfunction

   task automatic check_field(input string name, input logic [FieldW-1:0] want,
                              input logic [FieldW-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= ReportLimit)
            $display("%s mismatch on result %0d: expected %0h, got %0h",
                     name, checked, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      day_out_type want;
      day_in_type  rec;
      if (reset) begin
         sym_frac = 17'd6554;
         asym_lvl = 17'd6554;
         eff_inf  = 17'd32768;
         eff_sus  = 17'd0;
         eff_sym  = 17'd41943;
         min_days = 5'd7;
      end else begin
         // results first, so a result never consumes an item taken at this edge
         if (rsp_strobe) begin
            if (expected_days.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportLimit)
                  $display("result %0d arrived with nothing expected", checked);
            end else begin
               want = expected_days.pop_front();
               check_field("infectious_left", FieldW'(want.cd),
                           FieldW'(rsp_infectious_left_out));
               check_field("infectious_elapsed", FieldW'(want.up),
                           FieldW'(rsp_infectious_elapsed_out));
               check_field("incubation_left", FieldW'(want.inc),
                           FieldW'(rsp_incubation_left_out));
               check_field("vaccine_day", FieldW'(want.vd),
                           FieldW'(rsp_vaccine_day_out));
               check_field("base_infectious", want.binf, rsp_base_infectious_out);
               check_field("infectious", want.inf, rsp_infectious_out);
               check_field("base_suscept", want.bsus, rsp_base_suscept_out);
               check_field("suscept", want.sus, rsp_suscept_out);
               check_field("symptomatic", FieldW'(want.sym),
                           FieldW'(rsp_symptomatic_out));
               check_field("case", FieldW'(want.cas), FieldW'(rsp_case_out));
               check_field("newly_infectious", FieldW'(want.fresh),
                           FieldW'(rsp_newly_infectious));
            end
            checked++;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               adps_pkg::CSR_SYM_FRAC: sym_frac = csr_data;
               adps_pkg::CSR_ASYM_LVL: asym_lvl = csr_data;
               adps_pkg::CSR_EFF_INF:  eff_inf  = csr_data;
               adps_pkg::CSR_EFF_SUS:  eff_sus  = csr_data;
               adps_pkg::CSR_EFF_SYM:  eff_sym  = csr_data;
               adps_pkg::CSR_MIN_DAYS: min_days = csr_data[adps_pkg::MinW-1:0];
               default: ;
            endcase
         end

         if (start && !busy) begin
            rec.cd   = req_infectious_left;
            rec.up   = req_infectious_elapsed;
            rec.inc  = req_incubation_left;
            rec.vd   = req_vaccine_day;
            rec.binf = req_base_infectious_in;
            rec.inf  = req_infectious_in;
            rec.bsus = req_base_suscept_in;
            rec.sus  = req_suscept_in;
            rec.sym  = req_symptomatic_in;
            rec.cas  = req_case_in;
            rec.draw = req_symptom_draw;
            rec.offs = req_duration_offset;
            expected_days.push_back(advance_day(rec));
         end

         waiting <= expected_days.size();
      end
   end

endmodule

// ===== tb/sv/agent_disease_progression_step_tb.sv =====
// agent_disease_progression_step_tb: drives person records and register
// settings into the disease progression step; disease_step_checker judges
// every result. Depends on adps_pkg and disease_step_checker.

module agent_disease_progression_step_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ClockHalf      = 5;
   localparam int ResetCycles    = 12;
   localparam int StallLimit     = 2000;  // idle cycles before giving up
   localparam int RandomPerPhase = 150;
   localparam int DrainCycles    = 20;    // margin past the pipeline's drain

   // register settings the run steps through
   typedef enum int {
      SET_RESET,     // values left by reset
      SET_IN_RANGE,  // random, inside documented ranges
      SET_ZERO,
      SET_TOP,       // documented maxima: 1.0 and 31 days
      SET_ALL_ONES,  // every data bit set, above 1.0
      SET_WIDE       // random over the full register width
   } setting_kind_type;

   typedef struct packed {
      logic [adps_pkg::CdW-1:0]   infectious_left;
      logic [adps_pkg::UpW-1:0]   infectious_elapsed;
      logic [adps_pkg::IncW-1:0]  incubation_left;
      logic [adps_pkg::VdW-1:0]   vaccine_day;
      logic [adps_pkg::FixW-1:0]  base_infectious_in;
      logic [adps_pkg::FixW-1:0]  infectious_in;
      logic [adps_pkg::FixW-1:0]  base_suscept_in;
      logic [adps_pkg::FixW-1:0]  suscept_in;
      logic                       symptomatic_in;
      logic                       case_in;
      logic [adps_pkg::DrawW-1:0] symptom_draw;
      logic [adps_pkg::OffW-1:0]  duration_offset;
   } person_rec_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [adps_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [adps_pkg::FixW-1:0]    csr_data = '0;
   logic                         start = 1'b0;
   logic                         busy;
   logic [adps_pkg::CdW-1:0]     req_infectious_left = '0;
   logic [adps_pkg::UpW-1:0]     req_infectious_elapsed = '0;
   logic [adps_pkg::IncW-1:0]    req_incubation_left = '0;
   logic [adps_pkg::VdW-1:0]     req_vaccine_day = '0;
   logic [adps_pkg::FixW-1:0]    req_base_infectious_in = '0;
   logic [adps_pkg::FixW-1:0]    req_infectious_in = '0;
   logic [adps_pkg::FixW-1:0]    req_base_suscept_in = '0;
   logic [adps_pkg::FixW-1:0]    req_suscept_in = '0;
   logic                         req_symptomatic_in = 1'b0;
   logic                         req_case_in = 1'b0;
   logic [adps_pkg::DrawW-1:0]   req_symptom_draw = '0;
   logic [adps_pkg::OffW-1:0]    req_duration_offset = '0;
   logic                         rsp_strobe;
   logic [adps_pkg::CdW-1:0]     rsp_infectious_left_out;
   logic [adps_pkg::UpW-1:0]     rsp_infectious_elapsed_out;
   logic [adps_pkg::IncW-1:0]    rsp_incubation_left_out;
   logic [adps_pkg::VdW-1:0]     rsp_vaccine_day_out;
   logic [adps_pkg::FixW-1:0]    rsp_base_infectious_out;
   logic [adps_pkg::FixW-1:0]    rsp_infectious_out;
   logic [adps_pkg::FixW-1:0]    rsp_base_suscept_out;
   logic [adps_pkg::FixW-1:0]    rsp_suscept_out;
   logic                         rsp_symptomatic_out;
   logic                         rsp_case_out;
   logic                         rsp_newly_infectious;

   int unsigned mismatches;   // from the checker
   int unsigned waiting;      // results still owed, registered in the checker
   int unsigned checked;
   int          sent = 0;
   int          burst_left = 8;
   int          idle_cycles = 0;

   agent_disease_progression_step dut (.*);

   disease_step_checker watcher (.*);

   always #ClockHalf clock = ~clock;

   // Watchdog: the run is stuck if no item, result or register write
   // moves for StallLimit cycles.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
         $display("stalled for %0d cycles with %0d results owed", idle_cycles, waiting);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Q16 value: mostly inside 0..1.0, with the edges and full 17-bit noise
   function automatic logic [adps_pkg::FixW-1:0] rand_q16();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return adps_pkg::FixOne;
         2:       return adps_pkg::FixW'($urandom);
         default: return adps_pkg::FixW'($urandom_range(0, 65535));
      endcase
   endfunction

   // Random record weighted toward the interesting states: countdown at
   // zero, incubation ending, vaccine day inside the table.
   function automatic person_rec_type rand_person();
      person_rec_type p;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4:          p.infectious_left = '0;
         5, 6, 7, 8:             p.infectious_left = '1;          // none running
         9, 10, 11:              p.infectious_left = adps_pkg::CdW'($urandom);
         default:                p.infectious_left = adps_pkg::CdW'($urandom_range(1, 63));
      endcase
      case ($urandom_range(0, 9))
         0, 1:    p.infectious_elapsed = '1;                        // saturated
         2:       p.infectious_elapsed = 8'd254;
         3:       p.infectious_elapsed = '0;
         default: p.infectious_elapsed = adps_pkg::UpW'($urandom);
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6:    p.incubation_left = '0;          // onset today
         7, 8, 9, 10:            p.incubation_left = '1;
         11, 12, 13:             p.incubation_left = adps_pkg::IncW'($urandom);
         default:                p.incubation_left = adps_pkg::IncW'($urandom_range(1, 7));
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6:    p.vaccine_day = '1;               // unvaccinated
         7, 8, 9:                p.vaccine_day = adps_pkg::VdW'($urandom);
         default:
            p.vaccine_day = adps_pkg::VdW'($urandom_range(0, adps_pkg::VaccineDays - 1));
      endcase
      p.base_infectious_in = rand_q16();
      p.infectious_in      = rand_q16();
      p.base_suscept_in    = rand_q16();
      p.suscept_in         = rand_q16();
      p.symptomatic_in     = 1'($urandom);
      p.case_in            = 1'($urandom);
      // small draws land near the symptom thresholds more often
      p.symptom_draw       = ($urandom_range(0, 4) == 0)
                             ? adps_pkg::DrawW'($urandom_range(0, 8191))
                             : adps_pkg::DrawW'($urandom);
      p.duration_offset    = adps_pkg::OffW'($urandom);
      return p;
   endfunction

   // random record with the three state fields pinned
   function automatic person_rec_type shaped(input int cd, input int inc, input int vd);
      person_rec_type p;
      p = rand_person();
      p.infectious_left = adps_pkg::CdW'(cd);
      p.incubation_left = adps_pkg::IncW'(inc);
      p.vaccine_day     = adps_pkg::VdW'(vd);
      return p;
   endfunction

   // Present one item and hold it until taken. Items go out in bursts;
   // between bursts start drops for a random gap, sometimes none at all.
   task automatic offer(input person_rec_type p);
      int gap;
      req_infectious_left    <= p.infectious_left;
      req_infectious_elapsed <= p.infectious_elapsed;
      req_incubation_left    <= p.incubation_left;
      req_vaccine_day        <= p.vaccine_day;
      req_base_infectious_in <= p.base_infectious_in;
      req_infectious_in      <= p.infectious_in;
      req_base_suscept_in    <= p.base_suscept_in;
      req_suscept_in         <= p.suscept_in;
      req_symptomatic_in     <= p.symptomatic_in;
      req_case_in            <= p.case_in;
      req_symptom_draw       <= p.symptom_draw;
      req_duration_offset    <= p.duration_offset;
      start                  <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         case ($urandom_range(0, 5))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(8, 20);
            default: gap = $urandom_range(1, 4);
         endcase
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop sending and wait until every owed result is back. The first edge
   // lets the checker's count catch up with an item taken just now.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (waiting != 0);
   endtask

   function automatic logic [adps_pkg::FixW-1:0] setting_value(
         input setting_kind_type k, input adps_pkg::csr_index_type idx);
      logic is_days;
      is_days = (idx == adps_pkg::CSR_MIN_DAYS);
      case (k)
         SET_IN_RANGE: return is_days ? adps_pkg::FixW'($urandom_range(0, 31))
                                      : adps_pkg::FixW'($urandom_range(0, 65536));
         SET_ZERO:     return '0;
         SET_TOP:      return is_days ? adps_pkg::FixW'(31) : adps_pkg::FixOne;
         SET_ALL_ONES: return '1;
         default:      return adps_pkg::FixW'($urandom);
      endcase
   endfunction

   // Registers change only with the pipeline empty.
   task automatic apply_setting(input setting_kind_type k);
      adps_pkg::csr_index_type idx;
      settle();
      for (int i = 0; i <= int'(adps_pkg::CSR_MIN_DAYS); i++) begin
         idx = adps_pkg::csr_index_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= setting_value(k, idx);
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      person_rec_type   p;
      setting_kind_type k;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed records under the reset settings.
      p = shaped(5, -1, -1);                 // elapsed count reaches 255
      p.infectious_elapsed = 8'd254;
      offer(p);
      p = shaped(5, -1, -1);                 // elapsed count stays at 255
      p.infectious_elapsed = '1;
      offer(p);
      offer(shaped(63, -1, -1));             // longest countdown
      offer(shaped(0, -1, -1));              // infectiousness ends
      offer(shaped(-1, -1, -1));             // nothing running
      offer(shaped(-64, -1, -1));            // most negative countdown
      offer(shaped(-1, 7, -1));              // incubation counts down
      p = shaped(-1, 0, -1);                 // onset, smallest draw
      p.symptom_draw = '0;
      offer(p);
      p = shaped(-1, 0, -1);                 // draw just under default fraction
      p.symptom_draw = 16'd6553;
      offer(p);
      p = shaped(-1, 0, -1);                 // draw equal to default fraction
      p.symptom_draw = 16'd6554;
      offer(p);
      p = shaped(5, 0, -1);                  // onset over a running countdown
      p.symptom_draw    = '1;
      p.duration_offset = '1;
      offer(p);
      offer(shaped(-1, -8, -1));             // incubation below -1
      p = shaped(-1, 0, 0);                  // onset on the first vaccine day
      p.symptom_draw = '0;
      offer(p);
      p = shaped(0, 0, 20);                  // onset with full buildup
      p.symptom_draw = 16'd2000;
      offer(p);
      offer(shaped(10, -1, 19));             // infectiousness scaled, day reaches 20
      p = shaped(0, -1, 20);                 // susceptibility scaled, day stays
      p.base_suscept_in = adps_pkg::FixOne;
      offer(p);
      p = shaped(-1, -1, 25);                // day past the table
      p.base_suscept_in = '1;
      offer(p);
      offer(shaped(3, -1, 31));              // largest vaccine day
      offer(shaped(-1, -1, -32));            // most negative vaccine day
      p = shaped(0, -1, 5);                  // zero base susceptibility untouched
      p.base_suscept_in = '0;
      offer(p);
      p = shaped(1, -1, 8);                  // every fraction at full width
      p.base_infectious_in = '1;
      p.infectious_in      = '1;
      p.base_suscept_in    = '1;
      p.suscept_in         = '1;
      offer(p);
      offer('0);                             // all-zero record

      // Random records under each register setting in turn.
      for (int s = int'(SET_RESET); s <= int'(SET_WIDE); s++) begin
         k = setting_kind_type'(s);
         if (k != SET_RESET) apply_setting(k);
         repeat (RandomPerPhase) offer(rand_person());
      end

      settle();
      repeat (DrainCycles) @(posedge clock);

      $display("sent %0d person records across %0d register settings",
               sent, int'(SET_WIDE) + 1);
      $display("compared %0d results, %0d field mismatches", checked, mismatches);
      if (mismatches == 0 && waiting == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/adps_pkg.sv
design/agent_disease_progression_step.sv
tb/sv/disease_step_checker.sv
tb/sv/agent_disease_progression_step_tb.sv
